[rtl/core/fcma_pkg.sv]
// ----------------------------------------------------------------------------
// fcma_pkg
// Shared types for the four-channel boxcar moving average.
// ----------------------------------------------------------------------------
package fcma_pkg;

    typedef enum logic {
        ACT_UPDATE = 1'b0,
        ACT_FILL   = 1'b1
    } fcma_action_t;

    // Per-cycle strobes from the pipeline control to every lane
    typedef struct packed {
        logic rd_en;    // request accepted: read window entry at ring position
        logic stale;    // fill in flight: the entry just read is superseded
        logic commit;   // stage 1 advances: update sum and window
        logic fill;     // stage 1 request is a fill
        logic mean_en;  // stage 2 advances: register rounded mean
    } fcma_lane_ctl_t;

endpackage

[rtl/core/four_channel_moving_average_top.sv]
// ----------------------------------------------------------------------------
// four_channel_moving_average_top
// Four-lane boxcar moving average with running sums and rounded means.
// ----------------------------------------------------------------------------
// Pipeline: after acceptance a request passes the sum update, reciprocal
// multiply and merge/output registers before result_valid rises.
// Throughput: one request per cycle; the pipeline stalls only from result_stall.
// Reset: asynchronous, clears windows (via valid bits), sums, ring position
// and all pipeline valids; no clearing pass is needed.
module four_channel_moving_average_top #(
    parameter int WINDOW      = 15,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic                   action,
    input  logic [SAMPLE_BITS-1:0] rear_left_reading,
    input  logic [SAMPLE_BITS-1:0] rear_right_reading,
    input  logic [SAMPLE_BITS-1:0] target_left_reading,
    input  logic [SAMPLE_BITS-1:0] target_right_reading,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [SAMPLE_BITS-1:0] rear_left_mean,
    output logic [SAMPLE_BITS-1:0] rear_right_mean,
    output logic [SAMPLE_BITS-1:0] target_left_mean,
    output logic [SAMPLE_BITS-1:0] target_right_mean,
    output logic [SAMPLE_BITS:0]   rear_pair_total,
    output logic [SAMPLE_BITS:0]   target_pair_total
);

    localparam int AW = $clog2(WINDOW);

    logic                     v1_reg, v1_next;
    logic                     v2_reg, v2_next;
    logic                     v3_reg, v3_next;
    logic                     vo_reg, vo_next;
    logic                     s1_fill_reg, s1_fill_next;
    logic [AW-1:0]            s1_addr_reg, s1_addr_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic                     ld1, ld2, ld3, ld_o;
    logic                     accept;
    logic                     is_fill;
    fcma_pkg::fcma_lane_ctl_t lane_ctl;
    logic [SAMPLE_BITS-1:0]   rl_mean, rr_mean, tl_mean, tr_mean;

    // each stage moves when the next one is empty or moving
    assign ld_o   = ~vo_reg | ~result_stall;
    assign ld3    = ~v3_reg | ld_o;
    assign ld2    = ~v2_reg | ld3;
    assign ld1    = ~v1_reg | ld2;
    assign accept = sample_valid & ld1;
    assign is_fill = (fcma_pkg::fcma_action_t'(action) == fcma_pkg::ACT_FILL);

    assign sample_stall = ~ld1;
    assign result_valid = vo_reg;

    always_comb
    begin
        v1_next      = ld1  ? sample_valid : v1_reg;
        v2_next      = ld2  ? v1_reg       : v2_reg;
        v3_next      = ld3  ? v2_reg       : v3_reg;
        vo_next      = ld_o ? v3_reg       : vo_reg;
        s1_fill_next = s1_fill_reg;
        s1_addr_next = s1_addr_reg;
        pos_next     = pos_reg;
        if (accept)
        begin
            s1_fill_next = is_fill;
            s1_addr_next = pos_reg;
            if (!is_fill)
            begin
                pos_next = (pos_reg == AW'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            vo_reg      <= 1'b0;
            s1_fill_reg <= 1'b0;
            s1_addr_reg <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            vo_reg      <= vo_next;
            s1_fill_reg <= s1_fill_next;
            s1_addr_reg <= s1_addr_next;
            pos_reg     <= pos_next;
        end
    end

    always_comb
    begin
        lane_ctl.rd_en   = accept;
        // a fill committing now overrides whatever the new request reads
        lane_ctl.stale   = v1_reg & s1_fill_reg;
        lane_ctl.commit  = v1_reg & ld2;
        lane_ctl.fill    = s1_fill_reg;
        lane_ctl.mean_en = v2_reg & ld3;
    end

    fcma_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_rl (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lane_ctl),
        .rd_addr (pos_reg),
        .wr_addr (s1_addr_reg),
        .reading (rear_left_reading),
        .mean    (rl_mean)
    );

    fcma_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_rr (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lane_ctl),
        .rd_addr (pos_reg),
        .wr_addr (s1_addr_reg),
        .reading (rear_right_reading),
        .mean    (rr_mean)
    );

    fcma_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_tl (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lane_ctl),
        .rd_addr (pos_reg),
        .wr_addr (s1_addr_reg),
        .reading (target_left_reading),
        .mean    (tl_mean)
    );

    fcma_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_tr (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lane_ctl),
        .rd_addr (pos_reg),
        .wr_addr (s1_addr_reg),
        .reading (target_right_reading),
        .mean    (tr_mean)
    );

    fcma_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .clk               (clk),
        .load              (ld_o & v3_reg),
        .rl_mean           (rl_mean),
        .rr_mean           (rr_mean),
        .tl_mean           (tl_mean),
        .tr_mean           (tr_mean),
        .rear_left_mean    (rear_left_mean),
        .rear_right_mean   (rear_right_mean),
        .target_left_mean  (target_left_mean),
        .target_right_mean (target_right_mean),
        .rear_pair_total   (rear_pair_total),
        .target_pair_total (target_pair_total)
    );

endmodule

[rtl/core/fcma_lane.sv]
// ----------------------------------------------------------------------------
// fcma_lane
// One channel: sample window, running sum and rounded mean.
// ----------------------------------------------------------------------------
module fcma_lane #(
    parameter int WINDOW      = 15,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcma_pkg::fcma_lane_ctl_t    ctl,
    input  logic [$clog2(WINDOW)-1:0]   rd_addr,
    input  logic [$clog2(WINDOW)-1:0]   wr_addr,
    input  logic [SAMPLE_BITS-1:0]      reading,
    output logic [SAMPLE_BITS-1:0]      mean
);

    localparam int SW = $clog2(WINDOW * ((2 ** SAMPLE_BITS) - 1) + 1);
    // 2*sum + WINDOW stays below 2^XW
    localparam int XW    = SAMPLE_BITS + 1 + $clog2(WINDOW);
    localparam int DL    = $clog2(2 * WINDOW);
    localparam int SHIFT = XW + DL;
    localparam longint unsigned MulK =
        ((64'd1 << SHIFT) + 64'(2 * WINDOW) - 64'd1) / 64'(2 * WINDOW);
    localparam logic [XW:0] MUL_K = MulK[XW:0];

    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_q_reg;
    logic [SAMPLE_BITS-1:0] reading_s1_reg;
    logic                   rd_vld_reg;
    logic [WINDOW-1:0]      vbit_reg;
    logic [SAMPLE_BITS-1:0] fill_val_reg;
    logic [SW-1:0]          sum_reg;
    logic [SW-1:0]          sum_next;
    logic [SAMPLE_BITS-1:0] old_val;
    logic [XW-1:0]          dividend;
    logic [2*XW:0]          product;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [SAMPLE_BITS-1:0] mean_next;

    // Window store: one read port at request time, one write port at commit
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_q_reg       <= mem[rd_addr];
            reading_s1_reg <= reading;
        end
        if (ctl.commit && !ctl.fill)
        begin
            mem[wr_addr] <= reading_s1_reg;
        end
    end

    // Entries not written since the last fill (or reset) read as fill_val_reg
    always_comb
    begin
        old_val = rd_vld_reg ? rd_q_reg : fill_val_reg;
        if (ctl.fill)
        begin
            sum_next = SW'(reading_s1_reg) * SW'(WINDOW);
        end
        else
        begin
            sum_next = sum_reg - SW'(old_val) + SW'(reading_s1_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            vbit_reg     <= '0;
            fill_val_reg <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vbit_reg[rd_addr] & ~ctl.stale;
            end
            if (ctl.commit)
            begin
                sum_reg <= sum_next;
                if (ctl.fill)
                begin
                    vbit_reg     <= '0;
                    fill_val_reg <= reading_s1_reg;
                end
                else
                begin
                    vbit_reg[wr_addr] <= 1'b1;
                end
            end
        end
    end

    // round half up: floor((2*sum + W) / (2*W)) by reciprocal multiply
    always_comb
    begin
        dividend  = (XW'(sum_reg) << 1) + XW'(WINDOW);
        product   = {{(XW + 1){1'b0}}, dividend} * {{XW{1'b0}}, MUL_K};
        mean_next = product[SHIFT +: SAMPLE_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mean_en)
        begin
            mean_reg <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

[rtl/core/fcma_merge.sv]
// ----------------------------------------------------------------------------
// fcma_merge
// Combines the four lane means into the result, with pair totals.
// ----------------------------------------------------------------------------
module fcma_merge #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   clk,
    input  logic                   load,
    input  logic [SAMPLE_BITS-1:0] rl_mean,
    input  logic [SAMPLE_BITS-1:0] rr_mean,
    input  logic [SAMPLE_BITS-1:0] tl_mean,
    input  logic [SAMPLE_BITS-1:0] tr_mean,
    output logic [SAMPLE_BITS-1:0] rear_left_mean,
    output logic [SAMPLE_BITS-1:0] rear_right_mean,
    output logic [SAMPLE_BITS-1:0] target_left_mean,
    output logic [SAMPLE_BITS-1:0] target_right_mean,
    output logic [SAMPLE_BITS:0]   rear_pair_total,
    output logic [SAMPLE_BITS:0]   target_pair_total
);

    logic [SAMPLE_BITS-1:0] rl_reg;
    logic [SAMPLE_BITS-1:0] rr_reg;
    logic [SAMPLE_BITS-1:0] tl_reg;
    logic [SAMPLE_BITS-1:0] tr_reg;
    logic [SAMPLE_BITS:0]   rear_tot_reg;
    logic [SAMPLE_BITS:0]   target_tot_reg;
    logic [SAMPLE_BITS:0]   rear_tot_next;
    logic [SAMPLE_BITS:0]   target_tot_next;

    assign rear_tot_next   = {1'b0, rl_mean} + {1'b0, rr_mean};
    assign target_tot_next = {1'b0, tl_mean} + {1'b0, tr_mean};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rl_reg         <= rl_mean;
            rr_reg         <= rr_mean;
            tl_reg         <= tl_mean;
            tr_reg         <= tr_mean;
            rear_tot_reg   <= rear_tot_next;
            target_tot_reg <= target_tot_next;
        end
    end

    assign rear_left_mean    = rl_reg;
    assign rear_right_mean   = rr_reg;
    assign target_left_mean  = tl_reg;
    assign target_right_mean = tr_reg;
    assign rear_pair_total   = rear_tot_reg;
    assign target_pair_total = target_tot_reg;

endmodule

[rtl/core/fcma_checker.sv]
// ----------------------------------------------------------------------------
// fcma_checker
// Port-level checks for the four-channel moving average.
// ----------------------------------------------------------------------------
module fcma_checker #(
    parameter int SAMPLE_BITS = 10
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   sample_valid,
    input logic                   sample_stall,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [SAMPLE_BITS-1:0] rear_left_mean,
    input logic [SAMPLE_BITS-1:0] rear_right_mean,
    input logic [SAMPLE_BITS-1:0] target_left_mean,
    input logic [SAMPLE_BITS-1:0] target_right_mean,
    input logic [SAMPLE_BITS:0]   rear_pair_total,
    input logic [SAMPLE_BITS:0]   target_pair_total
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(rear_left_mean) && $stable(target_right_mean) &&
            $stable(rear_pair_total) && $stable(target_pair_total))
        else $error("stalled result changed");

    // totals must match the means they were built from
    a_pair_sums: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            rear_pair_total == ({1'b0, rear_left_mean} + {1'b0, rear_right_mean}) &&
            target_pair_total == ({1'b0, target_left_mean} + {1'b0, target_right_mean}))
        else $error("pair total mismatch");

    // an output that fills from empty traces back to an accepted request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid && !sample_stall, 4))
        else $error("result without matching request");

endmodule

bind four_channel_moving_average_top fcma_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fcma_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .sample_valid      (sample_valid),
    .sample_stall      (sample_stall),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .rear_left_mean    (rear_left_mean),
    .rear_right_mean   (rear_right_mean),
    .target_left_mean  (target_left_mean),
    .target_right_mean (target_right_mean),
    .rear_pair_total   (rear_pair_total),
    .target_pair_total (target_pair_total)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-channel boxcar moving average: a local
// window model predicts every result, a checker compares each one as it
// leaves the block, and the stimulus runs from directed edges to random
// bursts under random and long receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WINDOW         = 15;
    localparam int SAMPLE_BITS    = 10;
    localparam int CHANNELS       = 4;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int IDLE_LIMIT     = 4000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 12;
    localparam int REPORT_LINES   = 20;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SAMPLE_BITS:0]   total_t;

    typedef struct packed {
        sample_t rear_left;
        sample_t rear_right;
        sample_t target_left;
        sample_t target_right;
        total_t  rear_total;
        total_t  target_total;
    } mean_set_t;

    logic    clk;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_stall;
    logic    action;
    sample_t rear_left_reading;
    sample_t rear_right_reading;
    sample_t target_left_reading;
    sample_t target_right_reading;
    logic    result_valid;
    logic    result_stall;
    sample_t rear_left_mean;
    sample_t rear_right_mean;
    sample_t target_left_mean;
    sample_t target_right_mean;
    total_t  rear_pair_total;
    total_t  target_pair_total;

    four_channel_moving_average_top #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .sample_valid         (sample_valid),
        .sample_stall         (sample_stall),
        .action               (action),
        .rear_left_reading    (rear_left_reading),
        .rear_right_reading   (rear_right_reading),
        .target_left_reading  (target_left_reading),
        .target_right_reading (target_right_reading),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .rear_left_mean       (rear_left_mean),
        .rear_right_mean      (rear_right_mean),
        .target_left_mean     (target_left_mean),
        .target_right_mean    (target_right_mean),
        .rear_pair_total      (rear_pair_total),
        .target_pair_total    (target_pair_total)
    );

    // Model of the windows, kept in step with accepted requests
    sample_t     window_store [CHANNELS][WINDOW];
    int unsigned window_sum [CHANNELS];
    int unsigned ring_pos;
    mean_set_t   pending_means [$];

    int   mismatch_count;
    int   stuck_cycles;
    logic holdoff_request;
    logic holdoff_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sample_t rounded_mean(input int unsigned sum);
        int unsigned m;
        m = (2 * sum + WINDOW) / (2 * WINDOW);
        return sample_t'(m);
    endfunction

    task automatic average_windows(input fcma_pkg::fcma_action_t act, input sample_t rl,
                                   input sample_t rr, input sample_t tl, input sample_t tr);
        sample_t   rd [CHANNELS];
        sample_t   m [CHANNELS];
        mean_set_t res;
        rd[0] = rl;
        rd[1] = rr;
        rd[2] = tl;
        rd[3] = tr;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (act == fcma_pkg::ACT_FILL)
            begin
                for (int i = 0; i < WINDOW; i++)
                    window_store[ch][i] = rd[ch];
                window_sum[ch] = rd[ch] * WINDOW;
            end
            else
            begin
                window_sum[ch] = window_sum[ch] - window_store[ch][ring_pos] + rd[ch];
                window_store[ch][ring_pos] = rd[ch];
            end
            m[ch] = rounded_mean(window_sum[ch]);
        end
        // fill leaves the ring position where it was
        if (act == fcma_pkg::ACT_UPDATE)
            ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
        res.rear_left    = m[0];
        res.rear_right   = m[1];
        res.target_left  = m[2];
        res.target_right = m[3];
        res.rear_total   = total_t'(m[0]) + total_t'(m[1]);
        res.target_total = total_t'(m[2]) + total_t'(m[3]);
        pending_means.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < REPORT_LINES)
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Entered right after a falling edge, returns right after one
    task automatic offer_sample(input fcma_pkg::fcma_action_t act, input sample_t rl,
                                input sample_t rr, input sample_t tl, input sample_t tr);
        sample_valid         <= 1'b1;
        action               <= act;
        rear_left_reading    <= rl;
        rear_right_reading   <= rr;
        target_left_reading  <= tl;
        target_right_reading <= tr;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        average_windows(act, rl, rr, tl, tr);
        @(negedge clk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            // payload is noise while no request is offered
            sample_valid         <= 1'b0;
            action               <= 1'($urandom_range(0, 1));
            rear_left_reading    <= sample_t'($urandom);
            rear_right_reading   <= sample_t'($urandom);
            target_left_reading  <= sample_t'($urandom);
            target_right_reading <= sample_t'($urandom);
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic sample_t random_reading();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return sample_t'($urandom_range(0, 15));
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic offer_random_sample();
        fcma_pkg::fcma_action_t act;
        act = ($urandom_range(0, 11) == 0) ? fcma_pkg::ACT_FILL : fcma_pkg::ACT_UPDATE;
        offer_sample(act, random_reading(), random_reading(), random_reading(),
                     random_reading());
    endtask

    task automatic drain_results();
        idle_for(1);
        while (pending_means.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_reset_state();
        // windows start at zero, so a zero update gives zero means
        offer_sample(fcma_pkg::ACT_UPDATE, '0, '0, '0, '0);
        offer_sample(fcma_pkg::ACT_UPDATE, '1, '1, '1, '1);
    endtask

    task automatic test_directed_extremes();
        offer_sample(fcma_pkg::ACT_FILL, '1, '1, '1, '1);
        offer_sample(fcma_pkg::ACT_FILL, '0, '0, '0, '0);
        offer_sample(fcma_pkg::ACT_FILL, 10'h2AA, 10'h155, 10'h155, 10'h2AA);
        // rounding boundary: sum 7 rounds down, sum 8 rounds up
        offer_sample(fcma_pkg::ACT_FILL, '0, '0, '0, '0);
        offer_sample(fcma_pkg::ACT_UPDATE, 10'd7, 10'd7, 10'd7, 10'd7);
        offer_sample(fcma_pkg::ACT_UPDATE, 10'd1, 10'd1, 10'd1, 10'd1);
        // enough updates to wrap the ring position
        for (int i = 0; i < 16; i++)
        begin
            if (i % 2 == 0)
                offer_sample(fcma_pkg::ACT_UPDATE, '1, '0, '1, '0);
            else
                offer_sample(fcma_pkg::ACT_UPDATE, '0, '1, '0, '1);
        end
    endtask

    task automatic test_random_bursts(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 30);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                offer_random_sample();
                sent++;
            end
            idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
    endtask

    task automatic test_receiver_holdoff();
        // receiver holds off long enough that the block backs up into its input
        holdoff_request <= 1'b1;
        repeat (60) offer_random_sample();
        while (!holdoff_done)
            @(negedge clk);
        drain_results();
    endtask

    initial
    begin : result_receiver
        int mode;
        int mode_left;
        int holdoff_left;
        result_stall = 1'b0;
        holdoff_done = 1'b0;
        mode         = 0;
        mode_left    = 0;
        holdoff_left = 0;
        forever
        begin
            @(negedge clk);
            if (holdoff_request && !holdoff_done && holdoff_left == 0)
                holdoff_left = HOLDOFF_CYCLES;
            if (holdoff_left > 0)
            begin
                result_stall <= 1'b1;
                holdoff_left--;
                if (holdoff_left == 0)
                    holdoff_done <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 7) == 0);
                    2:       result_stall <= $urandom_range(0, 1);
                    default: result_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_checker
        mean_set_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_means.size() == 0)
                report_mismatch("result with no request pending", rear_left_mean, 0);
            else
            begin
                want = pending_means.pop_front();
                if (rear_left_mean !== want.rear_left)
                    report_mismatch("rear_left_mean", rear_left_mean, want.rear_left);
                if (rear_right_mean !== want.rear_right)
                    report_mismatch("rear_right_mean", rear_right_mean, want.rear_right);
                if (target_left_mean !== want.target_left)
                    report_mismatch("target_left_mean", target_left_mean, want.target_left);
                if (target_right_mean !== want.target_right)
                    report_mismatch("target_right_mean", target_right_mean,
                                    want.target_right);
                if (rear_pair_total !== want.rear_total)
                    report_mismatch("rear_pair_total", rear_pair_total, want.rear_total);
                if (target_pair_total !== want.target_total)
                    report_mismatch("target_pair_total", target_pair_total,
                                    want.target_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles >= IDLE_LIMIT)
        begin
            $display("four_channel_moving_average_top: mismatch");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin : test_sequence
        rst_n                = 1'b0;
        sample_valid         = 1'b0;
        action               = fcma_pkg::ACT_UPDATE;
        rear_left_reading    = '0;
        rear_right_reading   = '0;
        target_left_reading  = '0;
        target_right_reading = '0;
        holdoff_request      = 1'b0;
        mismatch_count       = 0;
        ring_pos             = 0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            window_sum[ch] = 0;
            for (int i = 0; i < WINDOW; i++)
                window_store[ch][i] = '0;
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_directed_extremes();
        drain_results();
        test_random_bursts(RANDOM_ITEMS / 2);
        drain_results();
        test_receiver_holdoff();
        test_random_bursts(RANDOM_ITEMS / 2);
        drain_results();

        if (mismatch_count == 0)
            $display("four_channel_moving_average_top: match");
        else
            $display("four_channel_moving_average_top: mismatch");
        $finish;
    end

endmodule
